// ----- hdl/hsvc_pkg.sv -----
// Shared types, constants and register indexes of the HSV colorize to YUV 4:2:0 block.
package hsvc_pkg;

    localparam int unsigned PIX_W    = 8;
    localparam int unsigned CFG_W    = 9;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned PROD_W   = 16;
    localparam int unsigned FRAC_W   = 6;
    localparam int unsigned SUM_W    = 20;

    localparam logic [CFG_IDX_W-1:0] CFG_HUE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SAT = 2'd1;

    localparam logic [CFG_W-1:0] SAT_ONE   = 9'd256;
    localparam logic [CFG_W-1:0] HUE_LIMIT = 9'd360;
    localparam logic [CFG_W-1:0] HUE_60    = 9'd60;
    localparam logic [CFG_W-1:0] HUE_120   = 9'd120;
    localparam logic [CFG_W-1:0] HUE_180   = 9'd180;
    localparam logic [CFG_W-1:0] HUE_240   = 9'd240;
    localparam logic [CFG_W-1:0] HUE_300   = 9'd300;

    // floor(n / 15) = (n * RECIP) >> SHIFT for n < 2^20
    localparam int unsigned     DIV15_SHIFT = 24;
    localparam logic [20:0]     DIV15_RECIP = 21'd1118482;

    // BT.601 limited range, Q0.10
    localparam logic [SUM_W-1:0] C_YR = 20'd263;
    localparam logic [SUM_W-1:0] C_YG = 20'd516;
    localparam logic [SUM_W-1:0] C_YB = 20'd100;
    localparam logic [SUM_W-1:0] C_UR = 20'd152;
    localparam logic [SUM_W-1:0] C_UG = 20'd298;
    localparam logic [SUM_W-1:0] C_UB = 20'd450;
    localparam logic [SUM_W-1:0] C_VR = 20'd450;
    localparam logic [SUM_W-1:0] C_VG = 20'd377;
    localparam logic [SUM_W-1:0] C_VB = 20'd73;
    localparam logic [SUM_W-1:0] C_OFS = 20'd131072;
    localparam logic [PIX_W-1:0] Y_OFS = 8'd16;

    typedef enum logic [2:0] {
        SEC_RY = 3'd0,
        SEC_YG = 3'd1,
        SEC_GC = 3'd2,
        SEC_CB = 3'd3,
        SEC_BM = 3'd4,
        SEC_MR = 3'd5
    } t_sector;

endpackage

// ----- hdl/hsvc_if.sv -----
// Stream and configuration interfaces of the HSV colorize to YUV 4:2:0 block.
interface hsvc_pix_if;
    import hsvc_pkg::*;
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic             even_column;
    logic             even_row;

    modport source (output valid, red, green, blue, even_column, even_row, input ready);
    modport sink   (input valid, red, green, blue, even_column, even_row, output ready);
endinterface

interface hsvc_yuv_if;
    import hsvc_pkg::*;
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] luma;
    logic [PIX_W-1:0] chroma_u;
    logic [PIX_W-1:0] chroma_v;
    logic             chroma_valid;

    modport source (output valid, luma, chroma_u, chroma_v, chroma_valid, input ready);
    modport sink   (input valid, luma, chroma_u, chroma_v, chroma_valid, output ready);
endinterface

interface hsvc_cfg_if;
    import hsvc_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- hdl/hsv_colorize_to_yuv420_top.sv -----
// Top level: HSV recolor of an RGB pixel stream and BT.601 YCbCr 4:2:0 conversion.
// Each pixel passes through register stages r1 to r6 and is held there during any output stall.
// Throughput: one pixel per cycle; six register stages advance together when the
// last stage is empty or its result is taken.
// Reset (synchronous, active low) empties the pipeline and sets hue and saturation to 0.
// Config writes are always taken; stages read registered copies, so pixels in flight may see new values.
module hsv_colorize_to_yuv420_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    hsvc_cfg_if.sink    i_cfg,
    hsvc_pix_if.sink    i_pix,
    hsvc_yuv_if.source  o_yuv
);
    import hsvc_pkg::*;

    localparam int unsigned NSTG = 6;

    // configuration and derived values
    logic [CFG_W-1:0]  r_hue;
    logic [CFG_W-1:0]  r_sat_cfg;
    logic [CFG_W-1:0]  r_sat;
    logic              r_hue_ok;
    logic [FRAC_W-1:0] r_f;
    t_sector           r_sector;

    logic [CFG_W-1:0]  n_sat;
    logic              n_hue_ok;
    logic [CFG_W-1:0]  n_hm;
    logic [CFG_W-1:0]  n_dist;
    logic [CFG_W-1:0]  n_fw;
    t_sector           n_sector;

    logic [NSTG-1:0]   r_vld;
    logic              adv;

    // stage payloads
    logic [PIX_W-1:0]  r1_r, r1_g, r1_b, r1_v;
    logic              r1_cv;
    logic [PIX_W-1:0]  r2_r, r2_g, r2_b, r2_v;
    logic              r2_cv;
    logic [PROD_W-1:0] r2_c, r2_mm;
    logic [PIX_W-1:0]  r3_r, r3_g, r3_b, r3_v;
    logic              r3_cv;
    logic [PROD_W-1:0] r3_c, r3_mm;
    logic [21:0]       r3_p;
    logic [PIX_W-1:0]  r4_r, r4_g, r4_b;
    logic              r4_cv;
    logic [PROD_W-1:0] r4_c, r4_mm, r4_x;
    logic [PIX_W-1:0]  r5_r, r5_g, r5_b;
    logic              r5_cv;
    logic [SUM_W-1:0]  r6_ys, r6_us, r6_vs;
    logic              r6_cv;

    logic [PIX_W-1:0]  n1_max;
    logic [PIX_W-1:0]  n1_v;
    logic [16:0]       n2_c, n2_mm;
    logic [21:0]       n3_p;
    logic [40:0]       n4_prod;
    logic [PROD_W-1:0] n5_sx, n5_sc;
    logic [PIX_W-1:0]  n5_bc, n5_bx, n5_b0;
    logic [PIX_W-1:0]  n5_r, n5_g, n5_b;
    logic [SUM_W-1:0]  n6_ys, n6_us, n6_vs;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hue     <= '0;
            r_sat_cfg <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_HUE: r_hue     <= i_cfg.data;
                CFG_SAT: r_sat_cfg <= i_cfg.data;
                default: ;
            endcase
        end
    end

    always_comb begin
        n_sat    = (r_sat_cfg > SAT_ONE) ? SAT_ONE : r_sat_cfg;
        n_hue_ok = (r_hue < HUE_LIMIT);
        if (r_hue < HUE_60)       n_sector = SEC_RY;
        else if (r_hue < HUE_120) n_sector = SEC_YG;
        else if (r_hue < HUE_180) n_sector = SEC_GC;
        else if (r_hue < HUE_240) n_sector = SEC_CB;
        else if (r_hue < HUE_300) n_sector = SEC_BM;
        else                      n_sector = SEC_MR;
        if (r_hue < HUE_120)      n_hm = r_hue;
        else if (r_hue < HUE_240) n_hm = r_hue - HUE_120;
        else                      n_hm = r_hue - HUE_240;
        n_dist = (n_hm >= HUE_60) ? (n_hm - HUE_60) : (HUE_60 - n_hm);
        n_fw   = HUE_60 - n_dist;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sat    <= '0;
            r_hue_ok <= 1'b1;
            r_f      <= '0;
            r_sector <= SEC_RY;
        end else begin
            r_sat    <= n_sat;
            r_hue_ok <= n_hue_ok;
            r_f      <= n_fw[FRAC_W-1:0];
            r_sector <= n_sector;
        end
    end

    // pipeline control
    assign adv         = !r_vld[NSTG-1] || o_yuv.ready;
    assign i_pix.ready = adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[NSTG-2:0], i_pix.valid};
        end
    end

    // datapath
    always_comb begin
        n1_max  = (i_pix.red > i_pix.green) ? i_pix.red : i_pix.green;
        n1_v    = (n1_max > i_pix.blue) ? n1_max : i_pix.blue;
        n2_c    = 17'(r1_v) * 17'(r_sat);
        n2_mm   = 17'(r1_v) * 17'(SAT_ONE - r_sat);
        n3_p    = 22'(r2_c) * 22'(r_f);
        n4_prod = 41'(r3_p[21:2]) * 41'(DIV15_RECIP);
        n5_sx   = r4_x + r4_mm;
        n5_sc   = r4_c + r4_mm;
        n5_bx   = n5_sx[PROD_W-1:PIX_W];
        n5_bc   = n5_sc[PROD_W-1:PIX_W];
        n5_b0   = r4_mm[PROD_W-1:PIX_W];
        if (r_hue_ok) begin
            case (r_sector)
                SEC_RY: begin n5_r = n5_bc; n5_g = n5_bx; n5_b = n5_b0; end
                SEC_YG: begin n5_r = n5_bx; n5_g = n5_bc; n5_b = n5_b0; end
                SEC_GC: begin n5_r = n5_b0; n5_g = n5_bc; n5_b = n5_bx; end
                SEC_CB: begin n5_r = n5_b0; n5_g = n5_bx; n5_b = n5_bc; end
                SEC_BM: begin n5_r = n5_bx; n5_g = n5_b0; n5_b = n5_bc; end
                default: begin n5_r = n5_bc; n5_g = n5_b0; n5_b = n5_bx; end
            endcase
        end else begin
            n5_r = r4_r;
            n5_g = r4_g;
            n5_b = r4_b;
        end
        // sums stay in [0, 2^18), so modular arithmetic is exact
        n6_ys = C_YR * SUM_W'(r5_r) + C_YG * SUM_W'(r5_g) + C_YB * SUM_W'(r5_b);
        n6_us = C_OFS + C_UB * SUM_W'(r5_b) - C_UR * SUM_W'(r5_r) - C_UG * SUM_W'(r5_g);
        n6_vs = C_OFS + C_VR * SUM_W'(r5_r) - C_VG * SUM_W'(r5_g) - C_VB * SUM_W'(r5_b);
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r1_r  <= i_pix.red;
            r1_g  <= i_pix.green;
            r1_b  <= i_pix.blue;
            r1_v  <= n1_v;
            r1_cv <= i_pix.even_column & i_pix.even_row;

            r2_r  <= r1_r;
            r2_g  <= r1_g;
            r2_b  <= r1_b;
            r2_v  <= r1_v;
            r2_cv <= r1_cv;
            r2_c  <= n2_c[PROD_W-1:0];
            r2_mm <= n2_mm[PROD_W-1:0];

            r3_r  <= r2_r;
            r3_g  <= r2_g;
            r3_b  <= r2_b;
            r3_v  <= r2_v;
            r3_cv <= r2_cv;
            r3_c  <= r2_c;
            r3_mm <= r2_mm;
            r3_p  <= n3_p;

            r4_r  <= r3_r;
            r4_g  <= r3_g;
            r4_b  <= r3_b;
            r4_cv <= r3_cv;
            r4_c  <= r3_c;
            r4_mm <= r3_mm;
            r4_x  <= n4_prod[DIV15_SHIFT +: PROD_W];

            r5_r  <= n5_r;
            r5_g  <= n5_g;
            r5_b  <= n5_b;
            r5_cv <= r4_cv;

            r6_ys <= n6_ys;
            r6_us <= n6_us;
            r6_vs <= n6_vs;
            r6_cv <= r5_cv;
        end
    end

    assign o_yuv.valid        = r_vld[NSTG-1];
    assign o_yuv.luma         = r6_ys[17:10] + Y_OFS;
    assign o_yuv.chroma_u     = r6_us[17:10];
    assign o_yuv.chroma_v     = r6_vs[17:10];
    assign o_yuv.chroma_valid = r6_cv;

`ifndef SYNTHESIS
    a_hue_derived: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(r_hue) < HUE_LIMIT |-> (r_hue_ok && r_f <= FRAC_W'(60)))
        else $error("derived hue fraction out of range");

    a_c_plus_m: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[2] |-> (17'(r3_c) + 17'(r3_mm) == {1'b0, r3_v, 8'd0}))
        else $error("chroma plus offset differs from value");

    a_x_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[3] && r_hue_ok) |-> (r4_x <= r4_c))
        else $error("sector ramp exceeds chroma");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[NSTG-1] && !o_yuv.ready) |=> ($stable(r_vld) && $stable(r6_ys)))
        else $error("pipeline moved during output stall");
`endif

endmodule
